@@ rtl/core/c2e_pkg.sv @@
package c2e_pkg;

    // Fixed formats
    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 13;
    localparam int MAX_STAGES  = 24;

    localparam int FACE_W      = 3;
    localparam int PIX_W       = 12;
    localparam int FACE_SIZE_W = 13;
    localparam int SRC_SIZE_W  = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FACE_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;

    // Pixel-center normalization: ((2p+1) << FRAC_BITS) / face_size
    localparam int NUM_W = PIX_W + 1 + FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 2;
    localparam int DIV_W = FACE_SIZE_W + Q_W;
    localparam logic [Q_W-1:0] NORM_LIM = {2'b10, {FRAC_BITS{1'b0}}};

    // Direction, Q2.FRAC_BITS, scaled up to Q2.30 before the angle units
    localparam int U_W     = FRAC_BITS + 3;
    localparam int D_SHIFT = 30 - FRAC_BITS;
    localparam logic signed [U_W-1:0] ONE_U = {3'b001, {FRAC_BITS{1'b0}}};

    // Horizontal length: isqrt of (dx^2 + dz^2)
    localparam int S_W    = 2 * FRAC_BITS + 2;
    localparam int ROOT_W = FRAC_BITS + 1 + D_SHIFT;
    localparam int REM_W  = 2 * ROOT_W + 1;

    // CORDIC
    localparam int CW    = 34;
    localparam int ANG_W = 32;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_W-1:0] NEG_QUARTER  = 32'hC000_0000;

    // Source mapping and weights
    localparam int SIZE_W = COORD_BITS + 1;
    localparam int PROD_W = ANG_W + SIZE_W;
    localparam int W_W    = FRAC_BITS + 1;
    localparam int WP_W   = 2 * FRAC_BITS + 1;
    localparam logic [W_W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

    // Face vector coefficients
    localparam logic [1:0] CZ = 2'b00;
    localparam logic [1:0] CP = 2'b01;
    localparam logic [1:0] CN = 2'b11;

    typedef struct packed {
        logic [NUM_W-1:0]  rem_x;
        logic [Q_W-1:0]    q_x;
        logic              ovf_x;
        logic [NUM_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_y;
        logic              ovf_y;
        logic [FACE_W-1:0] face;
    } div_t;

    typedef struct packed {
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [U_W-1:0]   u0;
        logic signed [U_W-1:0]   u1;
        logic signed [U_W-1:0]   u2;
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     z;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        lane_t az;
        lane_t el;
    } cordic_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [ANG_W-1:0] atan_turn(input int i);
        logic [ANG_W-1:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Corner, right, up per face; listed from up.z down to corner.x
    function automatic logic [17:0] face_coefs(input logic [FACE_W-1:0] face);
        logic [17:0] c;
        case (face)
            3'd1:    c = {CZ, CP, CZ, CN, CZ, CZ, CP, CN, CN};
            3'd2:    c = {CP, CZ, CZ, CZ, CZ, CP, CN, CP, CN};
            3'd3:    c = {CN, CZ, CZ, CZ, CZ, CP, CP, CN, CN};
            3'd4:    c = {CZ, CP, CZ, CZ, CZ, CP, CN, CN, CN};
            3'd5:    c = {CZ, CP, CZ, CZ, CZ, CN, CP, CN, CP};
            default: c = {CZ, CP, CZ, CP, CZ, CZ, CN, CN, CP};
        endcase
        return c;
    endfunction

    function automatic logic signed [U_W-1:0] coef_term(input logic [1:0] c,
                                                        input logic signed [U_W-1:0] v);
        logic signed [U_W-1:0] r;
        case (c)
            CP:      r = v;
            CN:      r = -v;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/c2e_div_cell.sv @@
// One quotient bit of both pixel-center divisions.
module c2e_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic [c2e_pkg::FACE_SIZE_W-1:0]      divisor,
    input  logic                                 in_valid,
    input  c2e_pkg::div_t                        in_data,
    output logic                                 out_valid,
    output c2e_pkg::div_t                        out_data
);

    localparam int DW = c2e_pkg::DIV_W;
    localparam int NW = c2e_pkg::NUM_W;
    localparam int QW = c2e_pkg::Q_W;

    logic          valid_reg;
    c2e_pkg::div_t data_reg;
    c2e_pkg::div_t data_next;
    logic [DW-1:0] dsh;
    logic          ge_x;
    logic          ge_y;

    always_comb begin
        dsh  = DW'(divisor) << SHIFT;
        ge_x = DW'(in_data.rem_x) >= dsh;
        ge_y = DW'(in_data.rem_y) >= dsh;
        data_next       = in_data;
        data_next.rem_x = ge_x ? NW'(DW'(in_data.rem_x) - dsh) : in_data.rem_x;
        data_next.rem_y = ge_y ? NW'(DW'(in_data.rem_y) - dsh) : in_data.rem_y;
        data_next.q_x   = {in_data.q_x[QW-2:0], ge_x};
        data_next.q_y   = {in_data.q_y[QW-2:0], ge_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/c2e_sqrt_cell.sv @@
// One root bit of the horizontal length, digit by digit.
module c2e_sqrt_cell #(
    parameter int J = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  c2e_pkg::sqrt_t in_data,
    output logic           out_valid,
    output c2e_pkg::sqrt_t out_data
);

    localparam int RW = c2e_pkg::REM_W;
    localparam int TW = c2e_pkg::ROOT_W;

    logic             valid_reg;
    c2e_pkg::sqrt_t   data_reg;
    c2e_pkg::sqrt_t   data_next;
    logic [RW-1:0]    trial;
    logic             ge;

    // rem holds v - root^2; try setting bit J: (root + 2^J)^2 - root^2
    always_comb begin
        trial = (RW'(in_data.root) << (J + 1)) | (RW'(1) << (2 * J));
        ge    = in_data.rem >= trial;
        data_next      = in_data;
        data_next.rem  = ge ? in_data.rem - trial : in_data.rem;
        data_next.root = ge ? (in_data.root | (TW'(1) << J)) : in_data.root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/c2e_cordic_cell.sv @@
// One vectoring micro-rotation for azimuth and elevation side by side.
module c2e_cordic_cell #(
    parameter int I = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  c2e_pkg::cordic_t in_data,
    output logic             out_valid,
    output c2e_pkg::cordic_t out_data
);

    localparam logic [c2e_pkg::ANG_W-1:0] ATAN = c2e_pkg::atan_turn(I);

    logic             valid_reg;
    c2e_pkg::cordic_t data_reg;
    c2e_pkg::cordic_t data_next;

    function automatic c2e_pkg::lane_t rotate(input c2e_pkg::lane_t l);
        logic signed [c2e_pkg::CW-1:0] xv;
        logic signed [c2e_pkg::CW-1:0] yv;
        logic signed [c2e_pkg::CW-1:0] xs;
        logic signed [c2e_pkg::CW-1:0] ys;
        c2e_pkg::lane_t r;
        xv = l.x;
        yv = l.y;
        xs = xv >>> I;
        ys = yv >>> I;
        r  = l;
        if (yv > 0) begin
            r.x = xv + ys;
            r.y = yv - xs;
            r.z = l.z + ATAN;
        end else begin
            r.x = xv - ys;
            r.y = yv + xs;
            r.z = l.z - ATAN;
        end
        return r;
    endfunction

    always_comb begin
        data_next.az = rotate(in_data.az);
        data_next.el = rotate(in_data.el);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/cube_face_to_equirect_sampler_core.sv @@
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------------
// input     | s_valid / s_ready  | s_face, s_pix_x, s_pix_y
// result    | m_valid / m_ready  | m_left_col, m_right_col, m_top_row, m_bottom_row,
//           |                    | m_weight_tl, m_weight_tr, m_weight_bl, m_weight_br
// config    | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One item per cycle while results are taken; each item passes 25 + 31 + CORDIC_STAGES
// registers (72 at the default) from input to result. The depth is set by the 18 divider
// cells, the 31 square root cells and the CORDIC cells in series.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// The whole pipeline moves together; it holds only while a result sits unclaimed.
module cube_face_to_equirect_sampler_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_we,
    input  logic [c2e_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [c2e_pkg::CFG_DATA_W-1:0]         cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [c2e_pkg::FACE_W-1:0]             s_face,
    input  logic [c2e_pkg::PIX_W-1:0]              s_pix_x,
    input  logic [c2e_pkg::PIX_W-1:0]              s_pix_y,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [c2e_pkg::COORD_BITS-1:0]         m_left_col,
    output logic [c2e_pkg::COORD_BITS-1:0]         m_right_col,
    output logic [c2e_pkg::COORD_BITS-1:0]         m_top_row,
    output logic [c2e_pkg::COORD_BITS-1:0]         m_bottom_row,
    output logic [c2e_pkg::W_W-1:0]                m_weight_tl,
    output logic [c2e_pkg::W_W-1:0]                m_weight_tr,
    output logic [c2e_pkg::W_W-1:0]                m_weight_bl,
    output logic [c2e_pkg::W_W-1:0]                m_weight_br
);

    localparam int FRAC   = c2e_pkg::FRAC_BITS;
    localparam int CB     = c2e_pkg::COORD_BITS;
    localparam int Q_W    = c2e_pkg::Q_W;
    localparam int NUM_W  = c2e_pkg::NUM_W;
    localparam int DIV_W  = c2e_pkg::DIV_W;
    localparam int U_W    = c2e_pkg::U_W;
    localparam int S_W    = c2e_pkg::S_W;
    localparam int REM_W  = c2e_pkg::REM_W;
    localparam int ROOT_W = c2e_pkg::ROOT_W;
    localparam int CW     = c2e_pkg::CW;
    localparam int ANG_W  = c2e_pkg::ANG_W;
    localparam int SIZE_W = c2e_pkg::SIZE_W;
    localparam int PROD_W = c2e_pkg::PROD_W;
    localparam int W_W    = c2e_pkg::W_W;
    localparam int WP_W   = c2e_pkg::WP_W;
    localparam int FS_W   = c2e_pkg::FACE_SIZE_W;
    localparam int SS_W   = c2e_pkg::SRC_SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {1'b1, {CB{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers and their effective (clamped) values
    // ------------------------------------------------------------------
    logic [FS_W-1:0]   face_size_reg;
    logic [SS_W-1:0]   src_width_reg;
    logic [SS_W-1:0]   src_height_reg;
    logic [FS_W-1:0]   n_eff;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg  <= FS_W'(512);
            src_width_reg  <= SS_W'(4096);
            src_height_reg <= SS_W'(2048);
        end else if (cfg_we) begin
            unique case (cfg_index)
                c2e_pkg::REG_FACE_SIZE:  face_size_reg  <= cfg_wdata[FS_W-1:0];
                c2e_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SS_W-1:0];
                c2e_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SS_W-1:0];
                default: ;
            endcase
        end
    end

    // zero face size acts as one; source sizes clamp to 1 .. 2^COORD_BITS
    always_comb begin
        n_eff = (face_size_reg == '0) ? FS_W'(1) : face_size_reg;
        if (src_width_reg == '0) begin
            w_eff = SIZE_W'(1);
        end else if (SIZE_W'(src_width_reg) > SIZE_MAX) begin
            w_eff = SIZE_MAX;
        end else begin
            w_eff = SIZE_W'(src_width_reg);
        end
        if (src_height_reg == '0) begin
            h_eff = SIZE_W'(1);
        end else if (SIZE_W'(src_height_reg) > SIZE_MAX) begin
            h_eff = SIZE_MAX;
        end else begin
            h_eff = SIZE_W'(src_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Global advance: everything moves unless the result is stuck
    // ------------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Stage 0: pixel-center numerators, overflow check, face clamp
    // ------------------------------------------------------------------
    logic          s0_valid_reg;
    c2e_pkg::div_t s0_reg;
    c2e_pkg::div_t s0_next;
    logic [DIV_W-1:0] div_top;

    always_comb begin
        div_top       = DIV_W'(n_eff) << Q_W;
        s0_next.rem_x = NUM_W'({s_pix_x, 1'b1}) << FRAC;
        s0_next.rem_y = NUM_W'({s_pix_y, 1'b1}) << FRAC;
        s0_next.q_x   = '0;
        s0_next.q_y   = '0;
        // quotient would need more bits than the cells produce: saturates anyway
        s0_next.ovf_x = DIV_W'(s0_next.rem_x) >= div_top;
        s0_next.ovf_y = DIV_W'(s0_next.rem_y) >= div_top;
        // unknown face codes act as the right face
        s0_next.face  = (s_face > c2e_pkg::FACE_LAST) ? '0 : s_face;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= s0_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell, MSB first
    // ------------------------------------------------------------------
    logic          div_valid [Q_W];
    c2e_pkg::div_t div_data  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        if (k == 0) begin : g_first
            c2e_div_cell #(.SHIFT(Q_W - 1)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .divisor   (n_eff),
                .in_valid  (s0_valid_reg),
                .in_data   (s0_reg),
                .out_valid (div_valid[k]),
                .out_data  (div_data[k])
            );
        end else begin : g_next
            c2e_div_cell #(.SHIFT(Q_W - 1 - k)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .divisor   (n_eff),
                .in_valid  (div_valid[k-1]),
                .in_data   (div_data[k-1]),
                .out_valid (div_valid[k]),
                .out_data  (div_data[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Direction: corner + right*nx + up*ny, Q2.FRAC
    // ------------------------------------------------------------------
    logic                  u_valid_reg;
    logic signed [U_W-1:0] u_reg  [3];
    logic signed [U_W-1:0] u_next [3];
    logic [Q_W-1:0]        nx;
    logic [Q_W-1:0]        ny;
    logic signed [U_W-1:0] nx_s;
    logic signed [U_W-1:0] ny_s;
    logic [17:0]           coefs;
    c2e_pkg::div_t         dq;

    always_comb begin
        dq    = div_data[Q_W-1];
        // pixels past the face edge saturate to 2.0
        nx    = (dq.ovf_x || dq.q_x > c2e_pkg::NORM_LIM) ? c2e_pkg::NORM_LIM : dq.q_x;
        ny    = (dq.ovf_y || dq.q_y > c2e_pkg::NORM_LIM) ? c2e_pkg::NORM_LIM : dq.q_y;
        nx_s  = signed'(U_W'(nx));
        ny_s  = signed'(U_W'(ny));
        coefs = c2e_pkg::face_coefs(dq.face);
        for (int k = 0; k < 3; k++) begin
            u_next[k] = c2e_pkg::coef_term(coefs[2*k +: 2], c2e_pkg::ONE_U)
                      + c2e_pkg::coef_term(coefs[2*(3+k) +: 2], nx_s)
                      + c2e_pkg::coef_term(coefs[2*(6+k) +: 2], ny_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg <= 1'b0;
        end else if (en) begin
            u_valid_reg <= div_valid[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg <= u_next;
        end
    end

    // ------------------------------------------------------------------
    // Squares: dx^2 + dz^2 at Q4.60 (u scaled by 2^D_SHIFT each)
    // ------------------------------------------------------------------
    logic                    sq_valid_reg;
    c2e_pkg::sqrt_t          sq_reg;
    c2e_pkg::sqrt_t          sq_next;
    logic signed [2*U_W-1:0] sq0;
    logic signed [2*U_W-1:0] sq2;

    always_comb begin
        sq0          = u_reg[0] * u_reg[0];
        sq2          = u_reg[2] * u_reg[2];
        // the sum reaches 2^33 at the corners, so it is taken as unsigned
        sq_next.rem  = REM_W'(unsigned'(S_W'(sq0 + sq2))) << (2 * c2e_pkg::D_SHIFT);
        sq_next.root = '0;
        sq_next.u0   = u_reg[0];
        sq_next.u1   = u_reg[1];
        sq_next.u2   = u_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (en) begin
            sq_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain: one root bit per cell, MSB first
    // ------------------------------------------------------------------
    logic           rt_valid [ROOT_W];
    c2e_pkg::sqrt_t rt_data  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        if (j == 0) begin : g_first
            c2e_sqrt_cell #(.J(ROOT_W - 1)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (sq_valid_reg),
                .in_data   (sq_reg),
                .out_valid (rt_valid[j]),
                .out_data  (rt_data[j])
            );
        end else begin : g_next
            c2e_sqrt_cell #(.J(ROOT_W - 1 - j)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (rt_valid[j-1]),
                .in_data   (rt_data[j-1]),
                .out_valid (rt_valid[j]),
                .out_data  (rt_data[j])
            );
        end
    end

    // ------------------------------------------------------------------
    // CORDIC setup: azimuth atan2(dx, -dz), elevation atan2(dy, hz).
    // Left half-plane vectors are turned by a half turn first; a zero
    // vector is flagged and reads as angle 0 at the end.
    // ------------------------------------------------------------------
    logic                 cp_valid_reg;
    c2e_pkg::cordic_t     cp_reg;
    c2e_pkg::cordic_t     cp_next;
    c2e_pkg::sqrt_t       rq;
    logic signed [CW-1:0] d0;
    logic signed [CW-1:0] d1;
    logic signed [CW-1:0] d2;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] hz;

    always_comb begin
        rq = rt_data[ROOT_W-1];
        d0 = CW'(rq.u0) <<< c2e_pkg::D_SHIFT;
        d1 = CW'(rq.u1) <<< c2e_pkg::D_SHIFT;
        d2 = CW'(rq.u2) <<< c2e_pkg::D_SHIFT;
        ax = -d2;
        hz = signed'(CW'(rq.root));
        cp_next.az.zero = (ax == '0) && (d0 == '0);
        if (ax < 0) begin
            cp_next.az.x = -ax;
            cp_next.az.y = -d0;
            cp_next.az.z = c2e_pkg::HALF_TURN;
        end else begin
            cp_next.az.x = ax;
            cp_next.az.y = d0;
            cp_next.az.z = '0;
        end
        // hz is never negative
        cp_next.el.zero = (hz == '0) && (d1 == '0);
        cp_next.el.x    = hz;
        cp_next.el.y    = d1;
        cp_next.el.z    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_valid_reg <= 1'b0;
        end else if (en) begin
            cp_valid_reg <= rt_valid[ROOT_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg <= cp_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain: both angles resolve together, one stage per cell
    // ------------------------------------------------------------------
    logic             cd_valid [CORDIC_STAGES];
    c2e_pkg::cordic_t cd_data  [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        if (i == 0) begin : g_first
            c2e_cordic_cell #(.I(i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (cp_valid_reg),
                .in_data   (cp_reg),
                .out_valid (cd_valid[i]),
                .out_data  (cd_data[i])
            );
        end else begin : g_next
            c2e_cordic_cell #(.I(i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (cd_valid[i-1]),
                .in_data   (cd_data[i-1]),
                .out_valid (cd_valid[i]),
                .out_data  (cd_data[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Map angles onto the source: column = (az + 1/2) * W,
    // row = (el + 1/4) * 2H; elevation clamped to +-1/4 turn.
    // ------------------------------------------------------------------
    logic                    m1_valid_reg;
    logic [PROD_W-1:0]       prod_c_reg;
    logic [PROD_W-1:0]       prod_r_reg;
    c2e_pkg::cordic_t        cq;
    logic [ANG_W-1:0]        az_ang;
    logic signed [ANG_W-1:0] el_s;
    logic [ANG_W-1:0]        el_c;
    logic [ANG_W-1:0]        el_up;

    always_comb begin
        cq     = cd_data[CORDIC_STAGES-1];
        az_ang = (cq.az.zero ? '0 : cq.az.z) + c2e_pkg::HALF_TURN;
        el_s   = signed'(cq.el.zero ? '0 : cq.el.z);
        if (el_s > signed'(c2e_pkg::QUARTER_TURN)) begin
            el_c = c2e_pkg::QUARTER_TURN;
        end else if (el_s < signed'(c2e_pkg::NEG_QUARTER)) begin
            el_c = c2e_pkg::NEG_QUARTER;
        end else begin
            el_c = unsigned'(el_s);
        end
        el_up = el_c + c2e_pkg::QUARTER_TURN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= cd_valid[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_c_reg <= PROD_W'(az_ang) * PROD_W'(w_eff);
            prod_r_reg <= PROD_W'(el_up) * PROD_W'(h_eff);
        end
    end

    // ------------------------------------------------------------------
    // Integer texel, wrapped neighbors, three weight products
    // ------------------------------------------------------------------
    logic                m2_valid_reg;
    logic [CB-1:0]       col_reg;
    logic [CB-1:0]       rcol_reg;
    logic [CB-1:0]       row_reg;
    logic [CB-1:0]       brow_reg;
    logic [W_W-1:0]      wtr_reg;
    logic [W_W-1:0]      wbl_reg;
    logic [W_W-1:0]      wbr_reg;
    logic [SIZE_W-1:0]   col_raw;
    logic [SIZE_W:0]     row_raw;
    logic [SIZE_W-1:0]   col_w;
    logic [SIZE_W-1:0]   row_w;
    logic [SIZE_W-1:0]   rcol;
    logic [SIZE_W-1:0]   brow;
    logic [FRAC-1:0]     fx;
    logic [FRAC-1:0]     fy;
    logic [W_W-1:0]      fx_c;
    logic [W_W-1:0]      fy_c;
    logic [WP_W-1:0]     p_tr;
    logic [WP_W-1:0]     p_bl;
    logic [WP_W-1:0]     p_br;

    always_comb begin
        col_raw = prod_c_reg[PROD_W-1:ANG_W];
        fx      = prod_c_reg[ANG_W-1 -: FRAC];
        row_raw = prod_r_reg[PROD_W-1:ANG_W-1];
        fy      = prod_r_reg[ANG_W-2 -: FRAC];
        // a column or row equal to the size wraps to 0
        col_w   = (col_raw >= w_eff) ? '0 : col_raw;
        row_w   = (row_raw >= {1'b0, h_eff}) ? '0 : SIZE_W'(row_raw);
        rcol    = (col_w == w_eff - 1'b1) ? '0 : col_w + 1'b1;
        brow    = (row_w == h_eff - 1'b1) ? '0 : row_w + 1'b1;
        fx_c    = c2e_pkg::ONE_W - W_W'(fx);
        fy_c    = c2e_pkg::ONE_W - W_W'(fy);
        p_tr    = WP_W'(fx) * WP_W'(fy_c);
        p_bl    = WP_W'(fx_c) * WP_W'(fy);
        p_br    = WP_W'(fx) * WP_W'(fy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg  <= CB'(col_w);
            rcol_reg <= CB'(rcol);
            row_reg  <= CB'(row_w);
            brow_reg <= CB'(brow);
            wtr_reg  <= W_W'(p_tr >> FRAC);
            wbl_reg  <= W_W'(p_bl >> FRAC);
            wbr_reg  <= W_W'(p_br >> FRAC);
        end
    end

    // ------------------------------------------------------------------
    // Output register; top-left weight takes the rounding remainder
    // ------------------------------------------------------------------
    logic [CB-1:0]  o_col_reg;
    logic [CB-1:0]  o_rcol_reg;
    logic [CB-1:0]  o_row_reg;
    logic [CB-1:0]  o_brow_reg;
    logic [W_W-1:0] o_wtl_reg;
    logic [W_W-1:0] o_wtr_reg;
    logic [W_W-1:0] o_wbl_reg;
    logic [W_W-1:0] o_wbr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_col_reg  <= col_reg;
            o_rcol_reg <= rcol_reg;
            o_row_reg  <= row_reg;
            o_brow_reg <= brow_reg;
            o_wtl_reg  <= c2e_pkg::ONE_W - wtr_reg - wbl_reg - wbr_reg;
            o_wtr_reg  <= wtr_reg;
            o_wbl_reg  <= wbl_reg;
            o_wbr_reg  <= wbr_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_left_col   = o_col_reg;
    assign m_right_col  = o_rcol_reg;
    assign m_top_row    = o_row_reg;
    assign m_bottom_row = o_brow_reg;
    assign m_weight_tl  = o_wtl_reg;
    assign m_weight_tr  = o_wtr_reg;
    assign m_weight_bl  = o_wbl_reg;
    assign m_weight_br  = o_wbr_reg;

`ifndef SYNTH
    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((W_W+2)'(m_weight_tl) + (W_W+2)'(m_weight_tr)
                     + (W_W+2)'(m_weight_bl) + (W_W+2)'(m_weight_br)
                     == (W_W+2)'(c2e_pkg::ONE_W)))
        else $error("bilinear weights do not sum to one");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SIZE_W'(m_left_col) < w_eff && SIZE_W'(m_top_row) < h_eff))
        else $error("texel outside source image");

    a_neighbor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_right_col == m_left_col + 1'b1 || m_right_col == '0)
                     && (m_bottom_row == m_top_row + 1'b1 || m_bottom_row == '0)))
        else $error("neighbor texel is not next or wrapped");
`endif

endmodule

@@ bench/tb_cube_face_to_equirect_sampler_core.sv @@
`timescale 1ns / 1ps

module tb_cube_face_to_equirect_sampler_core;

    // Result item as seen on the m_ side
    typedef struct packed {
        logic [c2e_pkg::COORD_BITS-1:0] left_col;
        logic [c2e_pkg::COORD_BITS-1:0] right_col;
        logic [c2e_pkg::COORD_BITS-1:0] top_row;
        logic [c2e_pkg::COORD_BITS-1:0] bottom_row;
        logic [c2e_pkg::W_W-1:0]        weight_tl;
        logic [c2e_pkg::W_W-1:0]        weight_tr;
        logic [c2e_pkg::W_W-1:0]        weight_bl;
        logic [c2e_pkg::W_W-1:0]        weight_br;
    } taps_t;

    // Predicts the four source taps and weights of each accepted pixel and
    // holds them until the matching result item shows up.
    class tap_predictor;
        bit [c2e_pkg::FACE_SIZE_W-1:0] face_size_q;
        bit [c2e_pkg::SRC_SIZE_W-1:0]  src_w_q;
        bit [c2e_pkg::SRC_SIZE_W-1:0]  src_h_q;
        taps_t                         pending_taps[$];
        int                            mismatches;
        bit [31:0]                     atan_tab[16];
        int                            face_dir[6][9];

        function new();
            face_size_q = 512;
            src_w_q     = 4096;
            src_h_q     = 2048;
            mismatches  = 0;
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                         333772, 166886, 83443, 41722, 20861};
            // corner xyz, right xyz, up xyz
            face_dir = '{'{ 1, -1, -1,  0, 0,  1,  0, 1,  0},
                         '{-1, -1,  1,  0, 0, -1,  0, 1,  0},
                         '{-1,  1, -1,  1, 0,  0,  0, 0,  1},
                         '{-1, -1,  1,  1, 0,  0,  0, 0, -1},
                         '{-1, -1, -1,  1, 0,  0,  0, 1,  0},
                         '{ 1, -1,  1, -1, 0,  0,  0, 1,  0}};
        endfunction

        function void set_reg(logic [c2e_pkg::CFG_INDEX_W-1:0] idx,
                              logic [c2e_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                c2e_pkg::REG_FACE_SIZE:  face_size_q = val[c2e_pkg::FACE_SIZE_W-1:0];
                c2e_pkg::REG_SRC_WIDTH:  src_w_q     = val;
                c2e_pkg::REG_SRC_HEIGHT: src_h_q     = val;
                default: ;
            endcase
        endfunction

        // vectoring rotation, angle in 2^-32 turns
        function bit [31:0] vector_angle(longint x, longint y);
            bit [31:0] z;
            longint    nx;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < 16; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_tab[i];
                end else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_tab[i];
                end
                x = nx;
            end
            return z;
        endfunction

        function bit [63:0] int_root(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint pixel_center(bit [63:0] p, bit [63:0] n);
            bit [63:0] q;
            q = (((2 * p) + 1) << c2e_pkg::FRAC_BITS) / n;
            return (q > (64'd2 << c2e_pkg::FRAC_BITS)) ? (64'd2 << c2e_pkg::FRAC_BITS) : q;
        endfunction

        function bit [63:0] clamp_src(bit [63:0] v);
            if (v < 1) return 1;
            return (v > (64'd1 << c2e_pkg::COORD_BITS)) ? (64'd1 << c2e_pkg::COORD_BITS) : v;
        endfunction

        function void note_pixel(logic [c2e_pkg::FACE_W-1:0] face,
                                 logic [c2e_pkg::PIX_W-1:0] px,
                                 logic [c2e_pkg::PIX_W-1:0] py);
            int        f;
            longint    nx, ny, hz, e;
            longint    d[3];
            bit [31:0] az, el;
            bit [63:0] n, w, h, prod, col, row, fx, fy, wtr, wbl, wbr;
            taps_t     t;
            f  = (face > 5) ? 0 : face;
            n  = (face_size_q == 0) ? 1 : face_size_q;
            w  = clamp_src(src_w_q);
            h  = clamp_src(src_h_q);
            nx = pixel_center(px, n);
            ny = pixel_center(py, n);
            for (int k = 0; k < 3; k++)
                d[k] = (face_dir[f][k] * 65536 + face_dir[f][3+k] * nx
                        + face_dir[f][6+k] * ny) * 16384;
            az = vector_angle(-d[2], d[0]) + 32'h8000_0000;
            hz = int_root(64'(d[0] * d[0]) + 64'(d[2] * d[2]));
            el = vector_angle(hz, d[1]);
            e  = el;
            if (el[31]) e = e - 64'sd4294967296;
            if (e > 64'sh4000_0000) e = 64'sh4000_0000;
            if (e < -64'sh4000_0000) e = -64'sh4000_0000;
            prod = 64'(az) * w;
            col  = prod >> 32;
            fx   = (prod >> 16) & 64'hFFFF;
            prod = 64'(e + 64'sh4000_0000) * h;
            row  = prod >> 31;
            fy   = (prod >> 15) & 64'hFFFF;
            if (col >= w) col = 0;
            if (row >= h) row = 0;
            wtr = (fx * (65536 - fy)) >> 16;
            wbl = ((65536 - fx) * fy) >> 16;
            wbr = (fx * fy) >> 16;
            t.left_col   = col[c2e_pkg::COORD_BITS-1:0];
            t.right_col  = (col == w - 1) ? '0 : c2e_pkg::COORD_BITS'(col + 1);
            t.top_row    = row[c2e_pkg::COORD_BITS-1:0];
            t.bottom_row = (row == h - 1) ? '0 : c2e_pkg::COORD_BITS'(row + 1);
            t.weight_tr  = wtr[c2e_pkg::W_W-1:0];
            t.weight_bl  = wbl[c2e_pkg::W_W-1:0];
            t.weight_br  = wbr[c2e_pkg::W_W-1:0];
            t.weight_tl  = c2e_pkg::W_W'(65536 - wtr - wbl - wbr);
            pending_taps.push_back(t);
        endfunction

        function void check_taps(taps_t got);
            taps_t want;
            if (pending_taps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result item %p", $realtime, got);
                return;
            end
            want = pending_taps.pop_front();
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, want, got);
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [c2e_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [c2e_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [c2e_pkg::FACE_W-1:0]       s_face = '0;
    logic [c2e_pkg::PIX_W-1:0]        s_pix_x = '0;
    logic [c2e_pkg::PIX_W-1:0]        s_pix_y = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [c2e_pkg::COORD_BITS-1:0]   m_left_col;
    logic [c2e_pkg::COORD_BITS-1:0]   m_right_col;
    logic [c2e_pkg::COORD_BITS-1:0]   m_top_row;
    logic [c2e_pkg::COORD_BITS-1:0]   m_bottom_row;
    logic [c2e_pkg::W_W-1:0]          m_weight_tl;
    logic [c2e_pkg::W_W-1:0]          m_weight_tr;
    logic [c2e_pkg::W_W-1:0]          m_weight_bl;
    logic [c2e_pkg::W_W-1:0]          m_weight_br;

    tap_predictor taps_model = new();

    // percent of cycles the sender idles / the receiver stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    cube_face_to_equirect_sampler_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_face       (s_face),
        .s_pix_x      (s_pix_x),
        .s_pix_y      (s_pix_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_col   (m_left_col),
        .m_right_col  (m_right_col),
        .m_top_row    (m_top_row),
        .m_bottom_row (m_bottom_row),
        .m_weight_tl  (m_weight_tl),
        .m_weight_tr  (m_weight_tr),
        .m_weight_bl  (m_weight_bl),
        .m_weight_br  (m_weight_br)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: values seen here are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            taps_model.check_taps(taps_t'({m_left_col, m_right_col, m_top_row,
                                           m_bottom_row, m_weight_tl, m_weight_tr,
                                           m_weight_bl, m_weight_br}));
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold valid across back-to-back items; drop it only for a real gap.
    task automatic send_pixel(logic [c2e_pkg::FACE_W-1:0] f,
                              logic [c2e_pkg::PIX_W-1:0] px,
                              logic [c2e_pkg::PIX_W-1:0] py);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_face  <= f;
        s_pix_x <= px;
        s_pix_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        taps_model.note_pixel(f, px, py);
    endtask

    // Drain, let the pipe settle, then write all three registers.
    task automatic load_regs(int fs, int sw, int sh);
        s_valid <= 1'b0;
        while (taps_model.pending_taps.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= c2e_pkg::REG_FACE_SIZE;
        cfg_wdata <= c2e_pkg::CFG_DATA_W'(fs);
        taps_model.set_reg(c2e_pkg::REG_FACE_SIZE, c2e_pkg::CFG_DATA_W'(fs));
        @(posedge aclk);
        cfg_index <= c2e_pkg::REG_SRC_WIDTH;
        cfg_wdata <= c2e_pkg::CFG_DATA_W'(sw);
        taps_model.set_reg(c2e_pkg::REG_SRC_WIDTH, c2e_pkg::CFG_DATA_W'(sw));
        @(posedge aclk);
        cfg_index <= c2e_pkg::REG_SRC_HEIGHT;
        cfg_wdata <= c2e_pkg::CFG_DATA_W'(sh);
        taps_model.set_reg(c2e_pkg::REG_SRC_HEIGHT, c2e_pkg::CFG_DATA_W'(sh));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int fs_set[8];
        int sw_set[8];
        int sh_set[8];
        int lim;
        int f, px, py;
        // face size / source width / source height per phase; reset values first,
        // then the extremes, zero and out-of-range sizes, and a few odd ones
        fs_set = '{512, 1, 4096, 0, 8191, 3, 100, 17};
        sw_set = '{4096, 2, 8192, 0, 16383, 1, 8191, 3000};
        sh_set = '{2048, 2, 8192, 0, 16383, 1, 8191, 1500};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every face code incl. unknown ones, corners and far-out pixels
        for (int i = 0; i < 8; i++) begin
            send_pixel(c2e_pkg::FACE_W'(i), 12'd0, 12'd0);
            send_pixel(c2e_pkg::FACE_W'(i), 12'd511, 12'd511);
            send_pixel(c2e_pkg::FACE_W'(i), 12'd4095, (i < 4) ? 12'd0 : 12'd4095);
        end

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) load_regs(fs_set[ph], sw_set[ph], sh_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // mostly pixels inside the face, some anywhere in the 12-bit range
            lim = (fs_set[ph] == 0) ? 1 : ((fs_set[ph] > 4096) ? 4096 : fs_set[ph]);
            for (int i = 0; i < 140; i++) begin
                f  = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5);
                px = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(lim - 1);
                py = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(lim - 1);
                send_pixel(c2e_pkg::FACE_W'(f), c2e_pkg::PIX_W'(px), c2e_pkg::PIX_W'(py));
            end
        end

        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (taps_model.pending_taps.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (taps_model.mismatches == 0 && taps_model.pending_taps.size() == 0)
            $display("** cube_face_to_equirect_sampler_core: PASSED **");
        else
            $display("** cube_face_to_equirect_sampler_core: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("** cube_face_to_equirect_sampler_core: FAILED **");
        $finish;
    end

endmodule
